### design/a85enc_pkg.sv
// Shared types and constants of the base-85 stream encoder.
package a85enc_pkg;

	// Reciprocal of 85 scaled by 2^38; the quotient is product[63:38].
	localparam logic [31:0] DIV85_MUL    = 32'hC0C0C0C1;
	localparam int          DIV85_SHIFT  = 38;
	localparam int          QUOT_W       = 26;
	localparam logic [6:0]  RADIX        = 7'd85;
	localparam logic [6:0]  DIGIT_OFFSET = 7'd33;
	localparam logic [6:0]  CHAR_Z       = 7'h7A;
	localparam logic [6:0]  CHAR_TILDE   = 7'h7E;
	localparam logic [6:0]  CHAR_GT      = 7'h3E;
	localparam int          NUM_DIGITS   = 5;

	// One padded group handed from the byte packer to the converter.
	typedef struct packed {
		logic [31:0] word;
		logic        fin;
	} job_t;

	// Queue head as seen by the converter.
	typedef struct packed {
		logic avail;
		job_t job;
	} head_t;

endpackage

### design/a85enc_front.sv
// Byte packer: collects bytes into 32-bit groups and pushes finished groups.
module a85enc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              final_byte,
	input  logic              q_full,
	output logic              push,
	output a85enc_pkg::job_t  push_job
);

	logic [23:0] group_q;
	logic [1:0]  count_q;
	logic        accept;
	logic        close;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;
	assign close    = (count_q == 2'd3) || final_byte;
	assign push     = accept && close;

	// Left-justify the held bytes and the new one, padding with zero bytes.
	always_comb begin
		case (count_q)
			2'd0:    push_job.word = {data_byte, 24'h0};
			2'd1:    push_job.word = {group_q[7:0], data_byte, 16'h0};
			2'd2:    push_job.word = {group_q[15:0], data_byte, 8'h0};
			default: push_job.word = {group_q, data_byte};
		endcase
		push_job.fin = final_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (close) begin
				group_q <= '0;
				count_q <= '0;
			end else begin
				group_q <= {group_q[15:0], data_byte};
				count_q <= count_q + 2'd1;
			end
		end
	end

endmodule

### design/a85enc_fifo.sv
// Short queue of padded groups between the byte packer and the converter.
module a85enc_fifo #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  a85enc_pkg::job_t   push_job,
	output logic               full,
	input  logic               pop,
	output a85enc_pkg::head_t  head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	a85enc_pkg::job_t  slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == FULL_CNT);
	assign head.avail = (count_q != '0);
	assign head.job   = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### design/a85enc_back.sv
// Converter: turns one group into base-85 characters and drives the output beat.
module a85enc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  a85enc_pkg::head_t  head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [6:0]         out_char,
	output logic               run_last,
	output logic               stream_done
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUB,
		ST_EMIT,
		ST_TILDE,
		ST_GT
	} state_t;

	state_t                          state_q;
	logic [31:0]                     word_q;
	logic                            fin_q;
	logic                            zero_q;
	logic [a85enc_pkg::QUOT_W-1:0]   quot_q;
	logic [6:0]                      dig_q [a85enc_pkg::NUM_DIGITS];
	logic [2:0]                      idx_q;
	logic                            out_valid_q;
	logic [6:0]                      out_char_q;
	logic                            run_last_q;
	logic                            done_q;

	logic        load_ok;
	logic        out_load;
	logic [63:0] product;
	logic [6:0]  quot_x85;
	logic [6:0]  digit;
	logic        last_char;
	logic [6:0]  emit_char;

	assign load_ok  = !out_valid_q || !out_stall;
	assign out_load = load_ok && (state_q inside {ST_EMIT, ST_TILDE, ST_GT});
	assign pop      = (state_q == ST_IDLE) && head.avail;
	assign product  = 64'(word_q) * 64'(a85enc_pkg::DIV85_MUL);
	// The remainder is below 85, so seven bits of the subtraction suffice.
	assign quot_x85 = quot_q[6:0] * a85enc_pkg::RADIX;
	assign digit    = word_q[6:0] - quot_x85;
	assign last_char = zero_q || (idx_q == 3'(a85enc_pkg::NUM_DIGITS - 1));
	assign emit_char = zero_q ? a85enc_pkg::CHAR_Z
	                          : dig_q[idx_q] + a85enc_pkg::DIGIT_OFFSET;

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign run_last    = run_last_q;
	assign stream_done = done_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_SUB) begin
			dig_q[idx_q] <= digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			word_q      <= '0;
			fin_q       <= 1'b0;
			zero_q      <= 1'b0;
			quot_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			run_last_q  <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head.avail) begin
						word_q  <= head.job.word;
						fin_q   <= head.job.fin;
						zero_q  <= (head.job.word == '0);
						idx_q   <= (head.job.word == '0) ? 3'd0
						                                   : 3'(a85enc_pkg::NUM_DIGITS - 1);
						state_q <= (head.job.word == '0) ? ST_EMIT : ST_MUL;
					end
				end
				ST_MUL: begin
					quot_q  <= product[63:a85enc_pkg::DIV85_SHIFT];
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					word_q <= 32'(quot_q);
					if (idx_q == 3'd0) begin
						state_q <= ST_EMIT;
					end else begin
						idx_q   <= idx_q - 3'd1;
						state_q <= ST_MUL;
					end
				end
				ST_EMIT: begin
					if (load_ok) begin
						out_char_q  <= emit_char;
						run_last_q  <= last_char && !fin_q;
						done_q      <= 1'b0;
						if (last_char) begin
							state_q <= fin_q ? ST_TILDE : ST_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				ST_TILDE: begin
					if (load_ok) begin
						out_char_q  <= a85enc_pkg::CHAR_TILDE;
						run_last_q  <= 1'b0;
						done_q      <= 1'b0;
						state_q     <= ST_GT;
					end
				end
				ST_GT: begin
					if (load_ok) begin
						out_char_q  <= a85enc_pkg::CHAR_GT;
						run_last_q  <= 1'b1;
						done_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### design/ascii85_stream_encoder.sv
// Top level of the base-85 stream encoder: byte packer, group queue and converter.
//
//  channel | valid     | stall     | beat fields
//  --------+-----------+-----------+--------------------------------------
//  input   | in_valid  | in_stall  | data_byte, final_byte
//  output  | out_valid | out_stall | out_char, run_last, stream_done
//
// The packer only stalls when the group queue is full. The converter takes a
// group from the queue, then for a nonzero group runs a 32x32 reciprocal multiply
// and a remainder step for each of five digits, on one shared unit, then emits its
// characters as the output accepts them: five for a nonzero group of four bytes,
// a single 'z' for a zero group, and the two trailer characters after a final
// group. Reset clears the open group, the queue and the output register; a stall
// on the output holds the current beat and the converter waits, while the packer
// keeps taking bytes until the queue fills.
module ascii85_stream_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] out_char,
	output logic       run_last,
	output logic       stream_done
);

	// Handoff between the packer and the queue.
	logic              q_full;
	logic              push;
	a85enc_pkg::job_t  push_job;

	// Handoff between the queue and the converter.
	logic              pop;
	a85enc_pkg::head_t head;

	// The front packs bytes big-endian and pads the final group with zeros.
	a85enc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	// The queue decouples the two sides so each can stall on its own.
	a85enc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head     (head)
	);

	// The back converts each group to digits and emits characters and trailer.
	a85enc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.run_last    (run_last),
		.stream_done (stream_done)
	);

endmodule

### sim/tb_ascii85_stream_encoder.sv
// Self-checking testbench for the base-85 stream encoder, with its own encoder model.
`timescale 1ns / 1ps

module tb_ascii85_stream_encoder;

	// The watchdog gives up after this many cycles in which neither channel moves a beat.
	// The slowest correct gap is the long receiver hold below, plus a group conversion.
	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD  = 200;
	localparam int DRAIN_WAIT = 40;

	// One encoded character as it should leave the output channel.
	typedef struct packed {
		logic [6:0] ch;
		logic       last;
		logic       done;
	} enc_char_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       final_byte;
	logic       out_valid;
	logic       out_stall;
	logic [6:0] out_char;
	logic       run_last;
	logic       stream_done;

	ascii85_stream_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.run_last   (run_last),
		.stream_done(stream_done)
	);

	// The model's copy of the open group: held bytes right-aligned, unused bytes zero.
	logic [23:0] grp_bytes;
	logic [1:0]  grp_count;

	// Characters the encoder owes us, oldest first.
	enc_char_t pending_chars[$];

	// Knobs shared between the stimulus and the receiver process.
	bit tx_idle;
	bit rx_idle;
	int hold_cycles;

	int mismatches;
	int bytes_sent;
	int chars_checked;
	int streams_closed;
	int zero_groups;
	int input_stalls;

	// Free-running clock, 10 ns period.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Appends one owed character at the tail of the list.
	task automatic owe_char(input enc_char_t c);
		pending_chars = {pending_chars, c};
	endtask

	// Model of one accepted byte. Bytes collect big-endian into a 32-bit word. A word
	// is converted once it has four bytes, or early when the byte is marked final; in
	// that case the missing low bytes are zero. A zero word becomes a single 'z';
	// anything else becomes five base-85 digits, most significant first, each offset
	// by 33. A final byte appends the "~>" trailer and the group state starts over.
	task automatic encode_byte(input logic [7:0] b, input logic fin);
		logic [31:0] word;
		logic [6:0]  digit [5];
		int unsigned used;
		used = grp_count + 1;
		if (used < 4 && !fin) begin
			grp_bytes = {grp_bytes[15:0], b};
			grp_count = grp_count + 2'd1;
			return;
		end
		word = {grp_bytes, b} << (8 * (4 - used));
		grp_bytes = '0;
		grp_count = '0;
		if (word == 32'd0) begin
			owe_char('{a85enc_pkg::CHAR_Z, 1'b0, 1'b0});
			zero_groups++;
		end else begin
			for (int i = 4; i >= 0; i--) begin
				digit[i] = 7'(word % 32'(a85enc_pkg::RADIX)) + a85enc_pkg::DIGIT_OFFSET;
				word = word / 32'(a85enc_pkg::RADIX);
			end
			for (int i = 0; i < 5; i++)
				owe_char('{digit[i], 1'b0, 1'b0});
		end
		if (fin) begin
			// Only the closing '>' carries both flags; the trailer belongs to this byte.
			owe_char('{a85enc_pkg::CHAR_TILDE, 1'b0, 1'b0});
			owe_char('{a85enc_pkg::CHAR_GT, 1'b1, 1'b1});
			streams_closed++;
		end else begin
			pending_chars[pending_chars.size() - 1].last = 1'b1;
		end
	endtask

	// Offers one byte and returns in the time step of the edge that takes it. Valid is
	// only lowered when a gap starts, so back-to-back beats never see valid drop and
	// rise within one step. The payload is held for as long as the block stalls.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		final_byte <= fin;
		@(posedge clk);
		while (in_stall) begin
			input_stalls++;
			@(posedge clk);
		end
		encode_byte(b, fin);
		bytes_sent++;
	endtask

	// Random byte; zero-biased streams produce many all-zero groups and 'z' output.
	function automatic logic [7:0] pick_byte(input bit zero_bias);
		if (zero_bias)
			return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// A whole stream of random length; only its last byte is marked final.
	task automatic send_stream(input int len);
		bit zero_bias;
		zero_bias = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++)
			send_byte(pick_byte(zero_bias), i == len - 1);
	endtask

	// The sender goes quiet until every owed character has come out. It always waits
	// for a clock edge, so a following send never raises valid in the same step.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_chars.size() != 0);
	endtask

	// Hand-picked streams: byte extremes, a full maximum group, a full zero group,
	// final partial groups of one, two and three bytes, a partial group that pads to
	// zero, and a final byte that completes a group.
	task automatic test_directed();
		logic [7:0] s1 [9] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
		logic [7:0] s2 [6] = '{8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
		logic [7:0] s3 [3] = '{8'h12, 8'h34, 8'h56};
		logic [7:0] s4 [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
		send_byte(8'h00, 1'b1);
		foreach (s1[i]) send_byte(s1[i], i == 8);
		foreach (s2[i]) send_byte(s2[i], i == 5);
		foreach (s3[i]) send_byte(s3[i], i == 2);
		foreach (s4[i]) send_byte(s4[i], i == 3);
		wait_drained();
	endtask

	// Random streams with random gaps and stalls on both channels.
	task automatic test_random_streams(input int target);
		int stop_at;
		stop_at = bytes_sent + target;
		while (bytes_sent < stop_at)
			send_stream($urandom_range(1, 13));
		wait_drained();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering, so
	// the group queue fills and the input channel has to stall.
	task automatic test_output_backpressure();
		int stalls_before;
		stalls_before = input_stalls;
		tx_idle = 1'b0;
		hold_cycles = LONG_HOLD;
		send_stream(16);
		send_stream(14);
		wait_drained();
		if (input_stalls == stalls_before)
			$display("%0t: note: input never stalled during the long output hold", $time);
		tx_idle = 1'b1;
	endtask

	// Streams separated by full drains, so the block restarts from empty each time.
	task automatic test_drain_between_streams();
		for (int i = 0; i < 6; i++) begin
			send_stream($urandom_range(1, 9));
			wait_drained();
		end
	endtask

	// Last part: no idling on either side, beats at the block's full rate.
	task automatic test_steady_flow(input int target);
		int stop_at;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		stop_at = bytes_sent + target;
		while (bytes_sent < stop_at)
			send_stream($urandom_range(1, 12));
	endtask

	// Receiver: random stall bursts while enabled, and a long hold when the stimulus
	// asks for one. Each step sees at most one assignment.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
				out_stall <= 1'b0;
			end else if (rx_idle && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Checker: every beat taken on the output is compared with the oldest owed
	// character. Values are read right after the edge, so they are the ones the
	// edge itself sampled.
	initial begin
		enc_char_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_chars.size() == 0) begin
					$display("%0t: unexpected beat: out_char=%h run_last=%b stream_done=%b",
						$time, out_char, run_last, stream_done);
					mismatches++;
				end else begin
					want = pending_chars.pop_front();
					chars_checked++;
					if (out_char !== want.ch) begin
						$display("%0t: out_char expected %h actual %h", $time, want.ch, out_char);
						mismatches++;
					end
					if (run_last !== want.last) begin
						$display("%0t: run_last expected %b actual %b", $time, want.last,
							run_last);
						mismatches++;
					end
					if (stream_done !== want.done) begin
						$display("%0t: stream_done expected %b actual %b", $time, want.done,
							stream_done);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog: counts cycles in which no beat moves on either channel.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: timeout, %0d characters still owed", $time, pending_chars.size());
		$display("FAIL");
		$finish;
	end

	// Main sequence: reset once, then each test in turn, then the final drain.
	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		data_byte   = 8'h00;
		final_byte  = 1'b0;
		grp_bytes   = '0;
		grp_count   = '0;
		tx_idle     = 1'b1;
		rx_idle     = 1'b1;
		hold_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_streams(200);
		test_output_backpressure();
		test_drain_between_streams();
		test_steady_flow(80);

		// Everything is sent; wait for the last characters, then watch a little longer
		// for stray beats.
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Encoded %0d bytes in %0d streams; checked %0d characters, %0d zero groups.",
			bytes_sent, streams_closed, chars_checked, zero_groups);
		$display("Input was held back by the encoder for %0d cycles; %0d mismatches.",
			input_stalls, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
